/* rtl/double_ended_queue_core_defines.svh */
// Assertion macros for the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dq_pkg.sv */
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package dq_pkg;

  localparam int DATA_W = 32;

  // Command codes on in_cmd
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd1;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;
  localparam logic [2:0] CMD_DUMP       = 3'd5;
  localparam logic [2:0] CMD_DUMP_REV   = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Classified command; all flags low means no operation
  typedef struct packed {
    logic push;
    logic pop;
    logic at_back;
    logic clr;
    logic dump;
    logic rev;
  } dq_op_t;

  typedef struct packed {
    dq_op_t                     op;
    logic signed [DATA_W-1:0]   data;
  } dq_item_t;

  // Result payload without the count, whose width follows the depth
  typedef struct packed {
    logic signed [DATA_W-1:0]   data;
    logic [1:0]                 status;
    logic signed [DATA_W-1:0]   front;
    logic signed [DATA_W-1:0]   back;
    logic                       last;
  } dq_res_t;

endpackage
`default_nettype wire

/* rtl/dq_front.sv */
// Intake stage: decodes commands and buffers them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module dq_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_cmd,
  input  wire logic signed [31:0]  in_data_in,
  output logic                     q_valid,
  output dq_pkg::dq_item_t         q_item,
  input  wire logic                q_pop
);
  import dq_pkg::*;

  dq_item_t   entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push_en;
  dq_item_t   dec_item;

  function automatic dq_op_t decode(input logic [2:0] cmd);
    dq_op_t op;
    op = '0;
    case (cmd)
      CMD_PUSH_FRONT: op.push = 1'b1;
      CMD_POP_FRONT:  op.pop  = 1'b1;
      CMD_PUSH_BACK: begin
        op.push    = 1'b1;
        op.at_back = 1'b1;
      end
      CMD_POP_BACK: begin
        op.pop     = 1'b1;
        op.at_back = 1'b1;
      end
      CMD_CLEAR:      op.clr  = 1'b1;
      CMD_DUMP:       op.dump = 1'b1;
      CMD_DUMP_REV: begin
        op.dump = 1'b1;
        op.rev  = 1'b1;
      end
      default:        op = '0;
    endcase
    return op;
  endfunction

  assign in_stall = (fill_r == 2'd2);
  assign push_en  = in_valid && !in_stall;
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    dec_item.op   = decode(in_cmd);
    dec_item.data = in_data_in;
    wr_ptr_nxt    = push_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt    = q_pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt      = fill_r + {1'b0, push_en} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      entry_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule
`default_nettype wire

/* rtl/dq_back.sv */
// Execution stage: ring storage, end pointers and the command sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_core_defines.svh"
module dq_back #(
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  dq_pkg::dq_item_t       q_item,
  output logic                   q_pop,
  input  wire logic              out_free,
  output logic                   res_valid,
  output dq_pkg::dq_res_t        res,
  output logic [CW-1:0]          res_count
);
  import dq_pkg::*;

  localparam int            SW      = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [1:0]    S_IDLE  = 2'd0;
  localparam logic [1:0]    S_POPRD = 2'd1;
  localparam logic [1:0]    S_DUMP  = 2'd2;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_q;

  logic [1:0]               state_r, state_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     rev_r, rev_nxt;
  logic signed [DATA_W-1:0] front_r, front_nxt;
  logic signed [DATA_W-1:0] back_r, back_nxt;
  logic signed [DATA_W-1:0] popv_r, popv_nxt;
  logic                     popb_r, popb_nxt;

  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr, push_addr;
  logic                     full, empty, dump_last;
  logic signed [DATA_W-1:0] r_data, r_front, r_back;
  logic [1:0]               r_status;
  logic                     r_last;

  // (base + off) mod DEPTH; operands keep the sum below twice the depth
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full      = (count_r == DEPTH_C);
  assign empty     = (count_r == '0);
  assign dump_last = (idx_r == count_r);
  assign push_addr = q_item.op.at_back ? ring_add(head_r, count_r)
                                       : ring_add(head_r, DEPTH_C - ONE_C);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rev_nxt   = rev_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    popv_nxt  = popv_r;
    popb_nxt  = popb_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = push_addr;
    rd_en     = 1'b0;
    rd_addr   = '0;
    res_valid = 1'b0;
    r_data    = '0;
    r_status  = ST_OK;
    r_last    = 1'b1;
    res_count = count_r;
    r_front   = front_r;
    r_back    = back_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.op.push) begin
            res_valid = 1'b1;
            if (full) begin
              r_status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              if (!q_item.op.at_back) begin
                head_nxt = push_addr;
              end
              count_nxt = count_r + ONE_C;
              if (!q_item.op.at_back || empty) begin
                front_nxt = q_item.data;
              end
              if (q_item.op.at_back || empty) begin
                back_nxt = q_item.data;
              end
              r_data    = q_item.data;
              res_count = count_nxt;
              r_front   = front_nxt;
              r_back    = back_nxt;
            end
          end else if (q_item.op.pop) begin
            if (empty) begin
              res_valid = 1'b1;
              r_status  = ST_EMPTY;
            end else begin
              count_nxt = count_r - ONE_C;
              if (!q_item.op.at_back) begin
                head_nxt = ring_add(head_r, ONE_C);
              end
              if (count_r == ONE_C) begin
                res_valid = 1'b1;
                r_data    = front_r;
                res_count = count_nxt;
              end else begin
                // new end element comes from the ring next cycle
                rd_en     = 1'b1;
                rd_addr   = q_item.op.at_back ? ring_add(head_r, count_r - CW'(2))
                                              : ring_add(head_r, ONE_C);
                popv_nxt  = q_item.op.at_back ? back_r : front_r;
                popb_nxt  = q_item.op.at_back;
                state_nxt = S_POPRD;
              end
            end
          end else if (q_item.op.clr) begin
            head_nxt  = '0;
            count_nxt = '0;
            res_valid = 1'b1;
            r_status  = ST_EMPTY;
            res_count = '0;
          end else if (q_item.op.dump) begin
            if (empty) begin
              res_valid = 1'b1;
              r_status  = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = ring_add(head_r, q_item.op.rev ? count_r - ONE_C : '0);
              idx_nxt   = ONE_C;
              rev_nxt   = q_item.op.rev;
              state_nxt = S_DUMP;
            end
          end else begin
            res_valid = 1'b1;
          end
        end
      end
      S_POPRD: begin
        if (out_free) begin
          res_valid = 1'b1;
          r_data    = popv_r;
          if (popb_r) begin
            back_nxt = rd_q;
          end else begin
            front_nxt = rd_q;
          end
          r_front   = front_nxt;
          r_back    = back_nxt;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          res_valid = 1'b1;
          r_data    = rd_q;
          r_last    = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ring_add(head_r, rev_r ? count_r - ONE_C - idx_r : idx_r);
            idx_nxt = idx_r + ONE_C;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    res.data   = r_data;
    res.status = r_status;
    res.last   = r_last;
    res.front  = (res_count == '0) ? '0 : r_front;
    res.back   = (res_count == '0) ? '0 : r_back;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
      rev_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    back_r  <= back_nxt;
    popv_r  <= popv_nxt;
    popb_r  <= popb_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_item.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  `DQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DEPTH_C, "element count above depth")
  `DQ_ASSERT_IMP(a_res_slot, res_valid, out_free, "result with no free output slot")
  `DQ_ASSERT_IMP(a_pop_valid, q_pop, q_valid && (state_r == S_IDLE), "queue pop without item")
  `DQ_ASSERT_NXT(a_dump_hold, state_r == S_DUMP, (count_r == $past(count_r)) && (head_r == $past(head_r)), "ring changed during dump")

endmodule
`default_nettype wire

/* rtl/double_ended_queue_core.sv */
// Top level of the bounded double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
// Bounded deque of signed 32-bit values held in a DEPTH-entry ring memory.
// Commands arrive on in_* (valid/stall) and land in a two-entry command
// queue, so intake keeps flowing while the execution side works or the
// output is stalled. Push, clear, unused codes and any empty/full refusal
// complete from the idle state. A pop that leaves elements behind adds a
// read state: the new front or back value is fetched through the single
// registered read port of the ring. A dump of n elements reads that same
// port once per element, and sets out_last on its final transfer; every other
// command gives exactly one transfer with out_last high. Each result carries
// the count and the front and back values after the command (zero when
// empty). Results pass through one output register; a held result stalls
// intake only once the two-entry command queue has filled behind it.
// No clearing pass is needed after reset.
module double_ended_queue_core #(
  parameter  int DEPTH = 32,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_cmd,
  input  wire logic signed [31:0] in_data_in,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_data_out,
  output logic [1:0]              out_status,
  output logic [CW-1:0]           out_count,
  output logic signed [31:0]      out_front_value,
  output logic signed [31:0]      out_back_value,
  output logic                    out_last
);
  import dq_pkg::*;

  logic          q_valid, q_pop;
  dq_item_t      q_item;
  logic          res_valid;
  dq_res_t       res;
  logic [CW-1:0] res_count;

  logic          out_valid_r, out_valid_nxt;
  dq_res_t       out_res_r;
  logic [CW-1:0] out_count_r;
  logic          out_free;

  // Decode and buffer incoming commands
  dq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_data_in(in_data_in),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Ring storage and command execution
  dq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_free (out_free),
    .res_valid(res_valid),
    .res      (res),
    .res_count(res_count)
  );

  // Output register: free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r   <= res;
      out_count_r <= res_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_res_r.data;
  assign out_status      = out_res_r.status;
  assign out_count       = out_count_r;
  assign out_front_value = out_res_r.front;
  assign out_back_value  = out_res_r.back;
  assign out_last        = out_res_r.last;

endmodule
`default_nettype wire
